@@ hdl/sm4_pkg.sv @@
// sm4_pkg: shared constants, tables and round functions of the sm4 cipher core
// used by the word interfaces and the top level
// no dependencies

package sm4_pkg;

	localparam int HALF_W    = 64;
	localparam int BLOCK_W   = 128;
	localparam int RK_W      = 32;
	localparam int RK_DEPTH  = 32;
	localparam int CNT_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(RK_DEPTH - 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

	// opcodes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// system parameters fk0..fk3, concatenated
	localparam logic [BLOCK_W-1:0] FK_ALL =
		128'ha3b1bac6_56aa3350_677d9197_b27022dc;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// byte-wise s-box substitution
	function automatic logic [31:0] tau(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// t transform of the data rounds: s-box substitution, then linear map
	function automatic logic [31:0] mix_data(input logic [31:0] v);
		logic [31:0] s;
		s = tau(v);
		return s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
	endfunction

	// t' transform of the key schedule: s-box substitution, then linear map
	function automatic logic [31:0] mix_key(input logic [31:0] v);
		logic [31:0] s;
		s = tau(v);
		return s ^ rotl(s, 13) ^ rotl(s, 23);
	endfunction

	// ck constant: byte j = (4i + j) * 7 mod 256
	function automatic logic [31:0] round_const(input logic [CNT_W-1:0] i);
		logic [31:0] c;
		logic [7:0]  idx;
		c = '0;
		for (int j = 0; j < 4; j++) begin
			idx = {1'b0, i, 2'(j)};
			c   = {c[23:0], 8'(idx * 8'd7)};
		end
		return c;
	endfunction

	// final word reversal
	function automatic logic [BLOCK_W-1:0] swap_words(input logic [BLOCK_W-1:0] x);
		return {x[31:0], x[63:32], x[95:64], x[127:96]};
	endfunction

endpackage

@@ hdl/sm4_req_if.sv @@
// sm4_req_if: valid/ready channel carrying one block and its opcode per word
// depends on sm4_pkg for field widths

interface sm4_req_if
	import sm4_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [HALF_W-1:0] block_high;
	logic [HALF_W-1:0] block_low;

	modport source (output valid, opcode, block_high, block_low, input ready);
	modport sink   (input valid, opcode, block_high, block_low, output ready);
endinterface

@@ hdl/sm4_rsp_if.sv @@
// sm4_rsp_if: valid/ready channel carrying one result block per word
// depends on sm4_pkg for field widths

interface sm4_rsp_if
	import sm4_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] result_high;
	logic [HALF_W-1:0] result_low;

	modport source (output valid, result_high, result_low, input ready);
	modport sink   (input valid, result_high, result_low, output ready);
endinterface

@@ hdl/sm4_block_cipher_core.sv @@
// sm4_block_cipher_core: sm4 ecb cipher core, top level
// depends on sm4_pkg, sm4_req_if, sm4_rsp_if and sm4_ram
//
// Usage
// The key is written through the configuration port: index 0 holds key bytes
// 0..7, index 1 key bytes 8..15. Every write starts a new key expansion
// (a load step in ST_KEYINIT, then one round key per cycle into the round key
// ram); req.ready stays low until it is done. Write the key before the first
// block is sent.
// Each req word carries one block and an opcode (encrypt or decrypt). A word
// is taken only while the core is idle. The 32 rounds run one per cycle, the
// round key ram supplying one key per cycle with the read address issued one
// round ahead, so the result is loaded into the output register at the end of
// the last round and a new word can be taken only once the core is idle again.
// The output register decouples the two sides: a new block is taken while a
// result still waits. If rsp is stalled when the next result is finished, the
// core holds it and keeps req.ready low until the output register frees up.
// Reset clears the key registers and control state; the round keys are not
// valid until a key write has been made.

module sm4_block_cipher_core
	import sm4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	sm4_req_if.sink              req,
	sm4_rsp_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HALF_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYINIT,
		ST_EXPAND,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               res_valid_q;
	logic [HALF_W-1:0]  key_high_q;
	logic [HALF_W-1:0]  key_low_q;
	logic [BLOCK_W-1:0] x_q;
	logic [BLOCK_W-1:0] k_q;
	logic [BLOCK_W-1:0] res_q;
	logic               dec_q;

	logic               accept;
	logic               out_free;
	logic               load_res;
	logic [31:0]        rk;
	logic [31:0]        nx;
	logic [31:0]        nk;
	logic [BLOCK_W-1:0] x_next;
	logic [CNT_W-1:0]   raddr;
	logic [CNT_W-1:0]   cnt_inc;

	// handshakes
	assign req.ready = (state_q == ST_IDLE) && !cfg_we;
	assign accept    = req.valid && req.ready;
	assign out_free  = !res_valid_q || rsp.ready;
	assign load_res  = ((state_q == ST_RUN) && (cnt_q == ROUND_LAST) && out_free)
		|| ((state_q == ST_DRAIN) && out_free);
	assign cnt_inc   = cnt_q + CNT_W'(1);

	// data round: x4 = x0 ^ l(tau(x1 ^ x2 ^ x3 ^ rk))
	assign nx     = x_q[127:96] ^ mix_data(x_q[95:64] ^ x_q[63:32] ^ x_q[31:0] ^ rk);
	assign x_next = {x_q[95:0], nx};

	// key schedule round
	assign nk = k_q[127:96] ^ mix_key(k_q[95:64] ^ k_q[63:32] ^ k_q[31:0] ^ round_const(cnt_q));

	// round key read address, one round ahead; decryption walks the keys backwards
	always_comb begin
		if (state_q == ST_RUN) begin
			raddr = cnt_inc ^ {CNT_W{dec_q}};
		end else begin
			raddr = {CNT_W{req.opcode == OP_DECRYPT}};
		end
	end

	sm4_ram #(
		.WIDTH (RK_W),
		.DEPTH (RK_DEPTH)
	) u_rk_ram (
		.clk   (clk),
		.we    (state_q == ST_EXPAND),
		.waddr (cnt_q),
		.wdata (nk),
		.raddr (raddr),
		.rdata (rk)
	);

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state machine and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				state_q <= ST_KEYINIT;
				cnt_q   <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept) begin
							state_q <= ST_RUN;
							cnt_q   <= '0;
						end
					end
					ST_KEYINIT: begin
						state_q <= ST_EXPAND;
						cnt_q   <= '0;
					end
					ST_EXPAND: begin
						cnt_q <= cnt_inc;
						if (cnt_q == ROUND_LAST) begin
							state_q <= ST_IDLE;
						end
					end
					ST_RUN: begin
						cnt_q <= cnt_inc;
						if (cnt_q == ROUND_LAST) begin
							state_q <= out_free ? ST_IDLE : ST_DRAIN;
						end
					end
					ST_DRAIN: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= {req.block_high, req.block_low};
			dec_q <= (req.opcode == OP_DECRYPT);
		end else if (state_q == ST_RUN) begin
			x_q <= x_next;
		end

		if (state_q == ST_KEYINIT) begin
			k_q <= {key_high_q, key_low_q} ^ FK_ALL;
		end else if (state_q == ST_EXPAND) begin
			k_q <= {k_q[95:0], nk};
		end

		if (load_res) begin
			res_q <= swap_words((state_q == ST_DRAIN) ? x_q : x_next);
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.result_high = res_q[127:64];
	assign rsp.result_low  = res_q[63:0];

`ifndef SYNTHESIS
	// no block taken while round keys are being rebuilt
	a_no_accept_in_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXPAND || state_q == ST_KEYINIT) |-> !(req.valid && req.ready))
		else $error("block taken during key expansion");

	// the last round always leaves the run state
	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == ROUND_LAST && !cfg_we) |=> state_q != ST_RUN)
		else $error("round counter overran");

	// a fresh result only appears at the end of a block
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("result word without a finished block");

	// the high half of a held result is never overwritten while stalled
	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && rsp.valid && !rsp.ready) |=> $stable(rsp.result_high))
		else $error("stalled result overwritten");
`endif

endmodule

@@ hdl/sm4_ram.sv @@
// sm4_ram: generic single write port, single read port ram, registered read
// no dependencies

module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ dv/sm4_cipher_checker.sv @@
`timescale 1ns / 100ps
// sm4_cipher_checker: watches the key port and both word channels of the sm4 core
// predicts every result from its own key schedule and cipher rounds, compares in order
// depends on sm4_pkg, sm4_req_if and sm4_rsp_if

module sm4_cipher_checker
	import sm4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	sm4_req_if                   req,
	sm4_rsp_if                   rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [HALF_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   compared
);

	typedef logic [RK_DEPTH-1:0][RK_W-1:0] schedule_t;

	localparam int MAX_PRINTED = 30;

	// fk words of the key schedule
	localparam logic [BLOCK_W-1:0] SYS_PARAM = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

	// published test vector: key and plaintext are the same value
	localparam logic [BLOCK_W-1:0] KAT_PLAIN  = 128'h01234567_89abcdef_fedcba98_76543210;
	localparam logic [BLOCK_W-1:0] KAT_CIPHER = 128'h681edf34_d206965e_86b3e94f_536e4246;

	localparam logic [7:0] SUBST_TAB [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	logic [HALF_W-1:0]  key_high_q;
	logic [HALF_W-1:0]  key_low_q;
	schedule_t          round_keys;
	logic [BLOCK_W-1:0] expected_blocks [$];
	int                 fail_count = 0;

	assign mismatches = fail_count;

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic logic [31:0] rol(input logic [31:0] w, input int unsigned n);
		return (w << n) | (w >> (32 - n));
	endfunction

	function automatic logic [31:0] subst(input logic [31:0] w);
		return {SUBST_TAB[w[31:24]], SUBST_TAB[w[23:16]], SUBST_TAB[w[15:8]], SUBST_TAB[w[7:0]]};
	endfunction

	// t transform of the cipher rounds
	function automatic logic [31:0] round_mix(input logic [31:0] w);
		logic [31:0] s;
		s = subst(w);
		return s ^ rol(s, 2) ^ rol(s, 10) ^ rol(s, 18) ^ rol(s, 24);
	endfunction

	// t' transform of the key schedule
	function automatic logic [31:0] sched_mix(input logic [31:0] w);
		logic [31:0] s;
		s = subst(w);
		return s ^ rol(s, 13) ^ rol(s, 23);
	endfunction

	// ck word i: byte j is (4i + j) * 7 modulo 256
	function automatic logic [31:0] ck_word(input int unsigned i);
		logic [31:0] c;
		c = '0;
		for (int unsigned j = 0; j < 4; j++)
			c = {c[23:0], 8'((4 * i + j) * 7)};
		return c;
	endfunction

	function automatic schedule_t build_schedule(input logic [BLOCK_W-1:0] key);
		schedule_t   rk;
		logic [31:0] w0, w1, w2, w3, nk;
		{w0, w1, w2, w3} = key ^ SYS_PARAM;
		for (int unsigned i = 0; i < RK_DEPTH; i++) begin
			nk    = w0 ^ sched_mix(w1 ^ w2 ^ w3 ^ ck_word(i));
			rk[i] = nk;
			{w0, w1, w2, w3} = {w1, w2, w3, nk};
		end
		return rk;
	endfunction

	// 32 rounds, round keys reversed for decryption, words reversed at the end
	function automatic logic [BLOCK_W-1:0] cipher_block(input logic op,
			input logic [BLOCK_W-1:0] blk, input schedule_t rk);
		logic [31:0] x0, x1, x2, x3, nx, k;
		{x0, x1, x2, x3} = blk;
		for (int unsigned i = 0; i < RK_DEPTH; i++) begin
			k  = (op == OP_DECRYPT) ? rk[RK_DEPTH - 1 - i] : rk[i];
			nx = x0 ^ round_mix(x1 ^ x2 ^ x3 ^ k);
			{x0, x1, x2, x3} = {x1, x2, x3, nx};
		end
		return {x3, x2, x1, x0};
	endfunction

	// predictor sanity against the published vector, both directions
	initial begin
		if (cipher_block(OP_ENCRYPT, KAT_PLAIN, build_schedule(KAT_PLAIN)) !== KAT_CIPHER)
			report_mismatch("predictor encryption disagrees with the published vector");
		if (cipher_block(OP_DECRYPT, KAT_CIPHER, build_schedule(KAT_PLAIN)) !== KAT_PLAIN)
			report_mismatch("predictor decryption disagrees with the published vector");
	end

	always @(posedge clk or negedge arst_n) begin
		logic [BLOCK_W-1:0] want;
		if (!arst_n) begin
			expected_blocks.delete();
			key_high_q = '0;
			key_low_q  = '0;
			round_keys = '0;
			pending  <= 0;
			compared <= 0;
		end else begin
			// key register write, schedule rebuilt from both halves
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_HIGH: key_high_q = cfg_data;
					CFG_KEY_LOW:  key_low_q  = cfg_data;
				endcase
				round_keys = build_schedule({key_high_q, key_low_q});
			end

			// accepted block word
			if (req.valid && req.ready)
				expected_blocks.push_back(cipher_block(req.opcode,
					{req.block_high, req.block_low}, round_keys));

			// accepted result word against the oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("result %h_%h with nothing expected",
						rsp.result_high, rsp.result_low));
				end else begin
					want = expected_blocks.pop_front();
					if (rsp.result_high !== want[127:64])
						report_mismatch($sformatf("result %0d high half %h, expected %h",
							compared, rsp.result_high, want[127:64]));
					if (rsp.result_low !== want[63:0])
						report_mismatch($sformatf("result %0d low half %h, expected %h",
							compared, rsp.result_low, want[63:0]));
					compared <= compared + 1;
				end
			end

			pending <= expected_blocks.size();
		end
	end

endmodule

@@ dv/sm4_block_cipher_core_tb.sv @@
`timescale 1ns / 100ps
// sm4_block_cipher_core_tb: clock, reset, key writes and block words for the sm4 core
// depends on sm4_pkg, sm4_req_if, sm4_rsp_if, sm4_block_cipher_core and sm4_cipher_checker

module sm4_block_cipher_core_tb;
	import sm4_pkg::*;

	localparam int     SETTLE_CYCLES = 40;
	localparam int     DRAIN_CYCLES  = 40;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     SEGMENT_WORDS = 146;
	localparam longint LIMIT_NS      = 10_000_000;

	localparam logic [BLOCK_W-1:0] STD_VECTOR = 128'h01234567_89abcdef_fedcba98_76543210;
	localparam logic [BLOCK_W-1:0] STD_CIPHER = 128'h681edf34_d206965e_86b3e94f_536e4246;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [HALF_W-1:0]    cfg_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked    = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int enc_words     = 0;
	int dec_words     = 0;
	int reg_writes    = 0;
	int mismatches;
	int pending;
	int compared;

	sm4_req_if req_ch ();
	sm4_rsp_if rsp_ch ();

	sm4_block_cipher_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sm4_cipher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.compared   (compared)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results still outstanding", pending);
		$display("sm4_block_cipher_core verification failed");
		$finish;
	end

	// result side: random stalls, plus long hold-offs counted here
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_served != hold_asked) begin
				hold_left = HOLD_CYCLES;
				hold_served++;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// offer one block word, with a random gap first, and wait for it to be taken
	task automatic send_block(input logic op, input logic [BLOCK_W-1:0] blk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.block_high <= blk[127:64];
		req_ch.block_low  <= blk[63:0];
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (op == OP_DECRYPT)
			dec_words++;
		else
			enc_words++;
	endtask

	// key register write once the core has gone quiet
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] value);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
	endtask

	initial begin
		logic [BLOCK_W-1:0] blk;
		int unsigned        pick;

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_KEY_HIGH;
		cfg_data          <= '0;
		req_ch.valid      <= 1'b0;
		req_ch.opcode     <= OP_ENCRYPT;
		req_ch.block_high <= '0;
		req_ch.block_low  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// standard key and vector, then extreme and alternating blocks
		write_reg(CFG_KEY_HIGH, STD_VECTOR[127:64]);
		write_reg(CFG_KEY_LOW, STD_VECTOR[63:0]);
		send_block(OP_ENCRYPT, STD_VECTOR);
		send_block(OP_DECRYPT, STD_CIPHER);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '1);
		send_block(OP_ENCRYPT, {4{32'haaaa5555}});
		send_block(OP_DECRYPT, {4{32'h5555aaaa}});

		// key changed one half at a time
		write_reg(CFG_KEY_HIGH, '1);
		send_block(OP_ENCRYPT, STD_VECTOR);
		send_block(OP_DECRYPT, STD_VECTOR);
		write_reg(CFG_KEY_LOW, '1);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_DECRYPT, '1);

		// all-zero key
		write_reg(CFG_KEY_HIGH, '0);
		write_reg(CFG_KEY_LOW, '0);
		send_block(OP_ENCRYPT, '0);
		send_block(OP_ENCRYPT, '1);
		send_block(OP_DECRYPT, '0);
		send_block(OP_DECRYPT, STD_CIPHER);

		// random words in three idling phases, fresh key for every segment
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 0) begin
				send_idle_pct = 36;
				recv_idle_pct = 56;
			end else if (phase == 1) begin
				send_idle_pct = 56;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int seg = 0; seg < 4; seg++) begin
				// both halves, or only one of them
				pick = $urandom_range(2);
				if (pick != 2)
					write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
				if (pick != 1)
					write_reg(CFG_KEY_LOW, {$urandom, $urandom});
				// long output stall while words keep coming, core backs up
				if (seg == 1 && phase != 1)
					hold_asked++;
				for (int n = 0; n < SEGMENT_WORDS; n++) begin
					pick = $urandom_range(15);
					if (pick == 0)
						blk = BLOCK_W'(1) << $urandom_range(BLOCK_W - 1);
					else if (pick == 1)
						blk = ~(BLOCK_W'(1) << $urandom_range(BLOCK_W - 1));
					else
						blk = {$urandom, $urandom, $urandom, $urandom};
					send_block($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, blk);
				end
			end
		end

		// drain
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d encrypt and %0d decrypt words across %0d key register writes",
			enc_words, dec_words, reg_writes);
		$display("%0d results compared, %0d long output hold-offs of %0d cycles",
			compared, hold_served, HOLD_CYCLES);
		if (mismatches == 0)
			$display("sm4_block_cipher_core verification clean");
		else
			$display("sm4_block_cipher_core verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/sm4_pkg.sv
hdl/sm4_req_if.sv
hdl/sm4_rsp_if.sv
hdl/sm4_ram.sv
hdl/sm4_block_cipher_core.sv
dv/sm4_cipher_checker.sv
dv/sm4_block_cipher_core_tb.sv
